// ----- rtl/qpd_pkg.sv -----
// Shared types, widths, register codes and the torque saturation function.
package qpd_pkg;

    // Operand and intermediate widths.
    localparam int Q_W      = 16;
    localparam int Q_FRAC   = 14;
    localparam int GAIN_FRAC = 8;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 34;
    localparam int ERR_W    = SUM_W - Q_FRAC;
    localparam int RPROD_W  = 2 * Q_W;
    localparam int EPROD_W  = Q_W + ERR_W;
    localparam int ACC_W    = EPROD_W + 1;
    localparam int TORQUE_W = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTITUDE_GAIN = 1'b1;

    // Saturation bounds of the torque, at accumulator width.
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-TORQUE_W+1){1'b0}}, {(TORQUE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-TORQUE_W+1){1'b1}}, {(TORQUE_W-1){1'b0}}};

    // One input item.
    typedef struct packed {
        logic signed [Q_W-1:0] cur_q0;
        logic signed [Q_W-1:0] cur_q1;
        logic signed [Q_W-1:0] cur_q2;
        logic signed [Q_W-1:0] cur_q3;
        logic signed [Q_W-1:0] tgt_q0;
        logic signed [Q_W-1:0] tgt_q1;
        logic signed [Q_W-1:0] tgt_q2;
        logic signed [Q_W-1:0] tgt_q3;
        logic signed [Q_W-1:0] rate_x;
        logic signed [Q_W-1:0] rate_y;
        logic signed [Q_W-1:0] rate_z;
    } t_qpd_in;

    // One result item.
    typedef struct packed {
        logic signed [TORQUE_W-1:0] torque_x;
        logic signed [TORQUE_W-1:0] torque_y;
        logic signed [TORQUE_W-1:0] torque_z;
    } t_qpd_out;

    // Queue entry: attitude error plus the rates that go with it.
    typedef struct packed {
        logic signed [ERR_W-1:0] err_x;
        logic signed [ERR_W-1:0] err_y;
        logic signed [ERR_W-1:0] err_z;
        logic signed [Q_W-1:0]   rate_x;
        logic signed [Q_W-1:0]   rate_y;
        logic signed [Q_W-1:0]   rate_z;
    } t_qpd_cmd;

    // Floor shift by the gain fraction, then clamp to the torque range.
    function automatic logic signed [TORQUE_W-1:0] sat_torque(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] sh;
        logic signed [ACC_W-1:0] cl;
        sh = acc >>> GAIN_FRAC;
        if (sh > SAT_MAX) begin
            cl = SAT_MAX;
        end else if (sh < SAT_MIN) begin
            cl = SAT_MIN;
        end else begin
            cl = sh;
        end
        return cl[TORQUE_W-1:0];
    endfunction

endpackage

// ----- rtl/quaternion_pd_torque.sv -----
// Path: front product and sum registers, queue, back gain-product and output registers.
// Throughput: one item per cycle when not stalled; the front end pipelines the twelve
// quaternion products, the queue decouples it from the back end's gain multipliers.
// The front stalls only when queue entries plus items in flight fill the queue.
// Reset (synchronous, active low) empties the pipes and queue and clears both gains.
// Top level: quaternion PD attitude torque controller.
module quaternion_pd_torque #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qpd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [qpd_pkg::Q_W-1:0]             i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  qpd_pkg::t_qpd_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output qpd_pkg::t_qpd_out                   o_out_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic signed [qpd_pkg::Q_W-1:0] r_rate_gain;
    logic signed [qpd_pkg::Q_W-1:0] r_attitude_gain;

    logic              push;
    logic              pop;
    logic              q_empty;
    logic [CNT_W-1:0]  q_count;
    qpd_pkg::t_qpd_cmd push_data;
    qpd_pkg::t_qpd_cmd head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_gain     <= '0;
            r_attitude_gain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qpd_pkg::CFG_RATE_GAIN:     r_rate_gain     <= i_cfg_wdata;
                qpd_pkg::CFG_ATTITUDE_GAIN: r_attitude_gain <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front end: error vector.
    qpd_front #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Decoupling queue.
    qpd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (q_empty),
        .o_count     (q_count)
    );

    // Back end: torques.
    qpd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rate_gain     (r_rate_gain),
        .i_attitude_gain (r_attitude_gain),
        .i_head          (head),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_data      (o_out_data)
    );

    // The credit check must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count == CNT_W'(QUEUE_DEPTH)) |-> (!push || pop))
        else $error("queue push while full");

    // The back end pops only a filled queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (q_count != '0))
        else $error("queue pop while empty");

    // The fill count rises by one on a push without a pop.
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (q_count == $past(q_count) + 1'b1))
        else $error("queue count did not follow push");

    // The fill count never exceeds the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/qpd_front.sv -----
// Front end: accepts items, forms the attitude error vector in two stages.
module qpd_front #(
    parameter int DEPTH = 4,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  qpd_pkg::t_qpd_in   i_in_data,
    input  logic [CNT_W-1:0]   i_q_count,
    output logic               o_push,
    output qpd_pkg::t_qpd_cmd  o_push_data
);

    localparam int TOT_W = CNT_W + 1;

    logic r_v1;
    logic r_v2;
    logic accept;
    logic [TOT_W-1:0] in_flight;

    // Stage one: twelve products and the delayed rates.
    logic signed [qpd_pkg::PROD_W-1:0] r_px [4];
    logic signed [qpd_pkg::PROD_W-1:0] r_py [4];
    logic signed [qpd_pkg::PROD_W-1:0] r_pz [4];
    logic signed [qpd_pkg::Q_W-1:0]    r_rx;
    logic signed [qpd_pkg::Q_W-1:0]    r_ry;
    logic signed [qpd_pkg::Q_W-1:0]    r_rz;

    // Stage two: error sums.
    logic signed [qpd_pkg::SUM_W-1:0] sum_x;
    logic signed [qpd_pkg::SUM_W-1:0] sum_y;
    logic signed [qpd_pkg::SUM_W-1:0] sum_z;
    qpd_pkg::t_qpd_cmd r_cmd;
    qpd_pkg::t_qpd_cmd n_cmd;

    // Credit check: queue entries plus items in the pipe must leave a free slot.
    always_comb begin
        in_flight = TOT_W'(i_q_count) + TOT_W'(r_v1) + TOT_W'(r_v2);
        o_in_stall = (in_flight >= TOT_W'(DEPTH));
    end

    assign accept = i_in_valid && !o_in_stall;

    // Valid flags of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    // Products of target and current components.
    always_ff @(posedge i_clk) begin
        r_px[0] <= i_in_data.tgt_q1 * i_in_data.cur_q0;
        r_px[1] <= i_in_data.tgt_q0 * i_in_data.cur_q1;
        r_px[2] <= i_in_data.tgt_q3 * i_in_data.cur_q2;
        r_px[3] <= i_in_data.tgt_q2 * i_in_data.cur_q3;
        r_py[0] <= i_in_data.tgt_q2 * i_in_data.cur_q0;
        r_py[1] <= i_in_data.tgt_q3 * i_in_data.cur_q1;
        r_py[2] <= i_in_data.tgt_q0 * i_in_data.cur_q2;
        r_py[3] <= i_in_data.tgt_q1 * i_in_data.cur_q3;
        r_pz[0] <= i_in_data.tgt_q3 * i_in_data.cur_q0;
        r_pz[1] <= i_in_data.tgt_q2 * i_in_data.cur_q1;
        r_pz[2] <= i_in_data.tgt_q1 * i_in_data.cur_q2;
        r_pz[3] <= i_in_data.tgt_q0 * i_in_data.cur_q3;
        r_rx    <= i_in_data.rate_x;
        r_ry    <= i_in_data.rate_y;
        r_rz    <= i_in_data.rate_z;
    end

    // Four-term sums with the error quaternion sign pattern.
    always_comb begin
        sum_x = -qpd_pkg::SUM_W'(r_px[0]) + qpd_pkg::SUM_W'(r_px[1])
              + qpd_pkg::SUM_W'(r_px[2]) - qpd_pkg::SUM_W'(r_px[3]);
        sum_y =  qpd_pkg::SUM_W'(r_py[0]) - qpd_pkg::SUM_W'(r_py[1])
              + qpd_pkg::SUM_W'(r_py[2]) - qpd_pkg::SUM_W'(r_py[3]);
        sum_z =  qpd_pkg::SUM_W'(r_pz[0]) + qpd_pkg::SUM_W'(r_pz[1])
              + qpd_pkg::SUM_W'(r_pz[2]) + qpd_pkg::SUM_W'(r_pz[3]);
        // Dropping the low fraction bits is a floor shift back to Q5.14.
        n_cmd.err_x  = sum_x[qpd_pkg::SUM_W-1:qpd_pkg::Q_FRAC];
        n_cmd.err_y  = sum_y[qpd_pkg::SUM_W-1:qpd_pkg::Q_FRAC];
        n_cmd.err_z  = sum_z[qpd_pkg::SUM_W-1:qpd_pkg::Q_FRAC];
        n_cmd.rate_x = r_rx;
        n_cmd.rate_y = r_ry;
        n_cmd.rate_z = r_rz;
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_push      = r_v2;
    assign o_push_data = r_cmd;

endmodule

// ----- rtl/qpd_queue.sv -----
// Short queue of error commands between the front and back ends.
module qpd_queue #(
    parameter int DEPTH = 4,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  qpd_pkg::t_qpd_cmd  i_push_data,
    input  logic               i_pop,
    output qpd_pkg::t_qpd_cmd  o_head,
    output logic               o_empty,
    output logic [CNT_W-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    qpd_pkg::t_qpd_cmd r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;

    // Pointer advance with wrap at the last entry.
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= next_ptr(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= next_ptr(r_rptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ----- rtl/qpd_back.sv -----
// Back end: applies the gains, sums, shifts and saturates the torques.
module qpd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [qpd_pkg::Q_W-1:0] i_rate_gain,
    input  logic signed [qpd_pkg::Q_W-1:0] i_attitude_gain,
    input  qpd_pkg::t_qpd_cmd             i_head,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output qpd_pkg::t_qpd_out             o_out_data
);

    logic r_v1;
    logic r_ov;
    logic adv_out;
    logic adv1;

    logic signed [qpd_pkg::RPROD_W-1:0] r_pr [3];
    logic signed [qpd_pkg::EPROD_W-1:0] r_pe [3];
    logic signed [qpd_pkg::ACC_W-1:0]   acc  [3];
    qpd_pkg::t_qpd_out r_out;

    // Elastic handshake: each stage moves when the next one is free or moving.
    assign adv_out = !r_ov || !i_out_stall;
    assign adv1    = !r_v1 || adv_out;
    assign o_pop   = !i_q_empty && adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= o_pop;
            end
            if (adv_out) begin
                r_ov <= r_v1;
            end
        end
    end

    // Gain products.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pr[0] <= i_rate_gain * i_head.rate_x;
            r_pr[1] <= i_rate_gain * i_head.rate_y;
            r_pr[2] <= i_rate_gain * i_head.rate_z;
            r_pe[0] <= i_attitude_gain * i_head.err_x;
            r_pe[1] <= i_attitude_gain * i_head.err_y;
            r_pe[2] <= i_attitude_gain * i_head.err_z;
        end
    end

    // Sum of rate and attitude terms for each axis.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc[k] = qpd_pkg::ACC_W'(r_pr[k]) + qpd_pkg::ACC_W'(r_pe[k]);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv_out && r_v1) begin
            r_out.torque_x <= qpd_pkg::sat_torque(acc[0]);
            r_out.torque_y <= qpd_pkg::sat_torque(acc[1]);
            r_out.torque_z <= qpd_pkg::sat_torque(acc[2]);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

// ----- dv/quaternion_pd_torque_test.sv -----
// Self-checking testbench for the quaternion PD attitude torque controller.
`timescale 1ns / 1ps

module quaternion_pd_torque_test;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 8;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ITEMS  = 108;
    localparam int          PRINT_LIMIT  = 30;

    localparam logic signed [qpd_pkg::Q_W-1:0] QMAX = 16'sh7fff;
    localparam logic signed [qpd_pkg::Q_W-1:0] QMIN = 16'sh8000;
    localparam logic signed [qpd_pkg::Q_W-1:0] QONE = 16'sh4000;
    localparam logic signed [qpd_pkg::Q_W-1:0] QNEG1 = 16'shffff;
    localparam logic signed [qpd_pkg::Q_W-1:0] QLSB = 16'sh0001;

    // Holds the gains, predicts the torques of each accepted item and checks results in order.
    class torque_board;
        longint            rate_gain;
        longint            attitude_gain;
        qpd_pkg::t_qpd_out expected_torques[$];
        int                errors;

        function void set_gain(logic [qpd_pkg::CFG_IDX_W-1:0] idx,
                               logic [qpd_pkg::Q_W-1:0] value);
            logic signed [qpd_pkg::Q_W-1:0] sval;
            sval = value;
            if (idx == qpd_pkg::CFG_RATE_GAIN) begin
                rate_gain = sval;
            end else if (idx == qpd_pkg::CFG_ATTITUDE_GAIN) begin
                attitude_gain = sval;
            end
        endfunction

        // Gain products summed exactly, floor shift by the gain fraction, clamp to 32 bits.
        function logic signed [qpd_pkg::TORQUE_W-1:0] axis_torque(longint rate, longint err);
            longint acc;
            acc = rate_gain * rate + attitude_gain * err;
            acc = acc >>> qpd_pkg::GAIN_FRAC;
            if (acc > 64'sd2147483647) begin
                acc = 64'sd2147483647;
            end else if (acc < -64'sd2147483648) begin
                acc = -64'sd2147483648;
            end
            return acc[qpd_pkg::TORQUE_W-1:0];
        endfunction

        // Vector part of the attitude error, then one torque per axis.
        function qpd_pkg::t_qpd_out predict_torques(qpd_pkg::t_qpd_in it);
            longint            c0, c1, c2, c3, t0, t1, t2, t3;
            longint            ex, ey, ez;
            qpd_pkg::t_qpd_out res;
            c0 = it.cur_q0;
            c1 = it.cur_q1;
            c2 = it.cur_q2;
            c3 = it.cur_q3;
            t0 = it.tgt_q0;
            t1 = it.tgt_q1;
            t2 = it.tgt_q2;
            t3 = it.tgt_q3;
            ex = (-t1 * c0 + t0 * c1 + t3 * c2 - t2 * c3) >>> qpd_pkg::Q_FRAC;
            ey = (t2 * c0 - t3 * c1 + t0 * c2 - t1 * c3) >>> qpd_pkg::Q_FRAC;
            ez = (t3 * c0 + t2 * c1 + t1 * c2 + t0 * c3) >>> qpd_pkg::Q_FRAC;
            res.torque_x = axis_torque(longint'(it.rate_x), ex);
            res.torque_y = axis_torque(longint'(it.rate_y), ey);
            res.torque_z = axis_torque(longint'(it.rate_z), ez);
            return res;
        endfunction

        function void note_input(qpd_pkg::t_qpd_in it);
            expected_torques.insert(expected_torques.size(), predict_torques(it));
        endfunction

        function int pending();
            return expected_torques.size();
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_result(qpd_pkg::t_qpd_out got);
            qpd_pkg::t_qpd_out want;
            if (expected_torques.size() == 0) begin
                report($sformatf("result with no item outstanding: %0d %0d %0d",
                                 got.torque_x, got.torque_y, got.torque_z));
            end else begin
                want = expected_torques.pop_front();
                if (got.torque_x !== want.torque_x) begin
                    report($sformatf("torque_x got %0d expected %0d",
                                     got.torque_x, want.torque_x));
                end
                if (got.torque_y !== want.torque_y) begin
                    report($sformatf("torque_y got %0d expected %0d",
                                     got.torque_y, want.torque_y));
                end
                if (got.torque_z !== want.torque_z) begin
                    report($sformatf("torque_z got %0d expected %0d",
                                     got.torque_z, want.torque_z));
                end
            end
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [qpd_pkg::CFG_IDX_W-1:0]   cfg_idx = qpd_pkg::CFG_RATE_GAIN;
    logic [qpd_pkg::Q_W-1:0]         cfg_wdata = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    qpd_pkg::t_qpd_in                in_data = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    qpd_pkg::t_qpd_out               out_data;

    int                     send_idle_pct = 25;
    int                     recv_idle_pct = 62;
    int                     cycle_count = 0;
    torque_board            sb;

    quaternion_pd_torque dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the stall for the next cycle.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_data);
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offers one item after a random gap and returns at the edge of its transfer.
    task automatic send_item(input qpd_pkg::t_qpd_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sb.note_input(item);
    endtask

    // Writes both gains on consecutive edges while the block is idle.
    task automatic write_gains(input logic [qpd_pkg::Q_W-1:0] rate_val,
                               input logic [qpd_pkg::Q_W-1:0] att_val);
        cfg_we    <= 1'b1;
        cfg_idx   <= qpd_pkg::CFG_RATE_GAIN;
        cfg_wdata <= rate_val;
        @(posedge clk);
        sb.set_gain(qpd_pkg::CFG_RATE_GAIN, rate_val);
        cfg_idx   <= qpd_pkg::CFG_ATTITUDE_GAIN;
        cfg_wdata <= att_val;
        @(posedge clk);
        sb.set_gain(qpd_pkg::CFG_ATTITUDE_GAIN, att_val);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering items and waits until every expected torque has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Field value biased toward the extremes and unit magnitude.
    function automatic logic signed [qpd_pkg::Q_W-1:0] rand_field();
        case ($urandom_range(11))
            0:       return QMAX;
            1:       return QMIN;
            2:       return QONE;
            3:       return -QONE;
            4:       return QNEG1;
            5:       return qpd_pkg::Q_W'($signed($urandom_range(64)) - 32);
            default: return qpd_pkg::Q_W'($urandom);
        endcase
    endfunction

    function automatic qpd_pkg::t_qpd_in rand_item();
        qpd_pkg::t_qpd_in it;
        it.cur_q0 = rand_field();
        it.cur_q1 = rand_field();
        it.cur_q2 = rand_field();
        it.cur_q3 = rand_field();
        it.tgt_q0 = rand_field();
        it.tgt_q1 = rand_field();
        it.tgt_q2 = rand_field();
        it.tgt_q3 = rand_field();
        it.rate_x = rand_field();
        it.rate_y = rand_field();
        it.rate_z = rand_field();
        return it;
    endfunction

    // Field extremes, identity attitude, sign patterns, floor of small negatives,
    // and unnormalized quaternions.
    task automatic send_directed();
        send_item(qpd_pkg::t_qpd_in'{'0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0});
        send_item(qpd_pkg::t_qpd_in'{QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX,
                                     QMAX, QMAX, QMAX});
        send_item(qpd_pkg::t_qpd_in'{QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN,
                                     QMIN, QMIN, QMIN});
        send_item(qpd_pkg::t_qpd_in'{QONE, '0, '0, '0, QONE, '0, '0, '0,
                                     QMAX, QMIN, '0});
        send_item(qpd_pkg::t_qpd_in'{QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX,
                                     QMIN, QMIN, QMIN});
        send_item(qpd_pkg::t_qpd_in'{QMAX, QMIN, QMAX, QMIN, QMIN, QMAX, QMIN, QMAX,
                                     QMAX, QMIN, QMAX});
        send_item(qpd_pkg::t_qpd_in'{QMIN, QMAX, QMIN, QMAX, QMIN, QMIN, QMAX, QMAX,
                                     QNEG1, QNEG1, QNEG1});
        send_item(qpd_pkg::t_qpd_in'{QLSB, '0, '0, '0, '0, QLSB, '0, '0,
                                     QLSB, QNEG1, QLSB});
        send_item(qpd_pkg::t_qpd_in'{QNEG1, QNEG1, QNEG1, QNEG1, QNEG1, QNEG1, QNEG1,
                                     QNEG1, QNEG1, QNEG1, QNEG1});
        send_item(qpd_pkg::t_qpd_in'{QMAX, QMAX, QMAX, QMAX, QMIN, QMAX, QMIN, QMAX,
                                     '0, '0, '0});
    endtask

    initial begin
        logic [qpd_pkg::Q_W-1:0] rate_val;
        logic [qpd_pkg::Q_W-1:0] att_val;
        sb = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Gains straight out of reset are zero.
        repeat (3) send_item(rand_item());
        drain();

        // Directed items under both gain extremes.
        write_gains(QMAX, QMAX);
        send_directed();
        drain();
        write_gains(QMIN, QMIN);
        send_directed();
        drain();

        // Random phases: receiver-light, sender-light, then back to back.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin rate_val = QMIN; att_val = QMAX; end
                1: begin rate_val = QMAX; att_val = QMIN; end
                2: begin
                    rate_val = qpd_pkg::Q_W'($urandom);
                    att_val  = qpd_pkg::Q_W'($urandom);
                end
                3: begin rate_val = 16'h0100; att_val = 16'h0100; end
                4: begin rate_val = '0; att_val = qpd_pkg::Q_W'($urandom); end
                default: begin
                    rate_val = qpd_pkg::Q_W'($urandom);
                    att_val  = qpd_pkg::Q_W'($urandom);
                end
            endcase
            if (ph < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 62;
            end else if (ph < 4) begin
                send_idle_pct = 62;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_gains(rate_val, att_val);
            repeat (PHASE_ITEMS) send_item(rand_item());
            drain();
        end

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
